// ===== sv/hdds_pkg.sv =====
// Shared types, constants and tables for the display scanner.
`default_nettype none

package hdds_pkg;

  localparam int unsigned ValueW = 16;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned PosW   = 4;
  localparam int unsigned SegW   = 8;
  localparam int unsigned NibW   = 4;
  localparam int unsigned GroupW = 2;
  localparam int unsigned PlaceW = 3;
  localparam int unsigned RecipW = 32;
  localparam int unsigned ProdW  = ValueW + RecipW;

  localparam logic [PosW-1:0]   LastPos  = 4'd9;
  localparam logic [PosW-1:0]   FirstDec = 4'd4;
  localparam logic [PosW-1:0]   HexPointPos = 4'd3;
  localparam logic [PlaceW-1:0] OnesPlace = 3'd5;

  localparam logic [ModeW-1:0] ModeHex = 2'd0;
  localparam logic [ModeW-1:0] ModeDec = 2'd1;

  localparam int unsigned PointBit = 7;

  // gfedcba hex font
  localparam logic [6:0] SegFont [16] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
    7'h7F, 7'h6F, 7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71
  };

  // ceil(2^32 / w) per decimal place, place 0 is the hundred-thousands digit.
  // Zero gives a zero quotient; the ones place bypasses the multiply.
  localparam logic [RecipW-1:0] RecipPlace [8] = '{
    32'h0000_0000,  // 100000: always 0
    32'h0006_8DB9,  // 10000
    32'h0041_8938,  // 1000
    32'h028F_5C29,  // 100
    32'h1999_999A,  // 10
    32'h0000_0000,  // 1: bypassed
    32'h0000_0000,
    32'h0000_0000
  };

  // ceil(2^32 / (10*w)) per decimal place
  localparam logic [RecipW-1:0] RecipNext [8] = '{
    32'h0000_0000,
    32'h0000_0000,  // 100000: always 0
    32'h0006_8DB9,  // 10000
    32'h0041_8938,  // 1000
    32'h028F_5C29,  // 100
    32'h1999_999A,  // 10
    32'h0000_0000,
    32'h0000_0000
  };

  typedef struct packed {
    logic [PosW-1:0]   digit_index;
    logic [SegW-1:0]   segment_pattern;
    logic              nibble_on;
    logic [GroupW-1:0] nibble_index;
    logic [NibW-1:0]   nibble_bits;
  } hdds_res_t;

endpackage

`default_nettype wire

// ===== sv/hex_dec_bin_display_scanner_core.sv =====
// Top level of the display scanner: scan counter, input register, result register.
// Path: a word accepted into the input register passes the combinational decode and
// is loaded into the result register once that register is empty or not stalled.
// Throughput: one word per cycle while out_stall_i is low; the decode of hex nibble,
// decimal digit (two reciprocal multiplies) and font lookup fits one registered pass.
// Reset: asynchronous, clears the scan position to 0 and both stage valids.
`default_nettype none

module hex_dec_bin_display_scanner_core
  import hdds_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [ValueW-1:0] shown_value_i,
  input  wire logic [ModeW-1:0]  entry_mode_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [PosW-1:0]        digit_index_o,
  output logic [SegW-1:0]        segment_pattern_o,
  output logic                   nibble_on_o,
  output logic [GroupW-1:0]      nibble_index_o,
  output logic [NibW-1:0]        nibble_bits_o
);

  logic [PosW-1:0]   scan_q, scan_d;
  logic              s1_valid_q;
  logic [ValueW-1:0] s1_value_q;
  logic [ModeW-1:0]  s1_mode_q;
  logic [PosW-1:0]   s1_pos_q;
  logic              s2_valid_q;
  hdds_res_t         s2_res_q;
  hdds_res_t         dec_res;
  logic              in_accept;
  logic              s2_load;

  assign s2_load    = s1_valid_q && (!s2_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s2_load;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign scan_d     = (scan_q >= LastPos) ? '0 : scan_q + 4'd1;

  hdds_decode u_decode (
    .shown_value_i (s1_value_q),
    .entry_mode_i  (s1_mode_q),
    .scan_pos_i    (s1_pos_q),
    .res_o         (dec_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q     <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        scan_q <= scan_d;
      end
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s2_load) begin
        s1_valid_q <= 1'b0;
      end
      if (s2_load) begin
        s2_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_value_q <= shown_value_i;
      s1_mode_q  <= entry_mode_i;
      s1_pos_q   <= scan_q;
    end
    if (s2_load) begin
      s2_res_q <= dec_res;
    end
  end

  assign out_valid_o       = s2_valid_q;
  assign digit_index_o     = s2_res_q.digit_index;
  assign segment_pattern_o = s2_res_q.segment_pattern;
  assign nibble_on_o       = s2_res_q.nibble_on;
  assign nibble_index_o    = s2_res_q.nibble_index;
  assign nibble_bits_o     = s2_res_q.nibble_bits;

`ifndef SYNTHESIS
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_q <= LastPos)
    else $error("scan position out of range");

  a_scan_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> scan_q == (($past(scan_q) == LastPos) ? 4'd0 : $past(scan_q) + 4'd1))
    else $error("scan position did not advance");

  a_nibble_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (nibble_on_o == (digit_index_o < FirstDec)))
    else $error("nibble group lit on wrong digit");

  a_point_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && segment_pattern_o[PointBit]) |->
      (digit_index_o == HexPointPos || digit_index_o == LastPos))
    else $error("decimal point on wrong digit");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled word dropped");
`endif

endmodule

`default_nettype wire

// ===== sv/hdds_decode.sv =====
// Digit decode: hex nibble or decimal digit select, font lookup and point.
`default_nettype none

module hdds_decode
  import hdds_pkg::*;
(
  input  wire logic [ValueW-1:0] shown_value_i,
  input  wire logic [ModeW-1:0]  entry_mode_i,
  input  wire logic [PosW-1:0]   scan_pos_i,
  output hdds_res_t              res_o
);

  logic [PosW-1:0]   pos;
  logic [GroupW-1:0] group;
  logic [NibW-1:0]   nib;
  logic [PlaceW-1:0] place;
  logic [ProdW-1:0]  prod_w;
  logic [ProdW-1:0]  prod_next;
  logic [ValueW-1:0] quo_w;
  logic [ValueW-1:0] quo_next;
  logic [ValueW-1:0] dec_diff;
  logic [NibW-1:0]   dec_digit;
  logic              is_hex;
  logic              point;

  always_comb begin
    pos    = (scan_pos_i > LastPos) ? '0 : scan_pos_i;
    is_hex = (pos < FirstDec);
    group  = 2'd3 - pos[GroupW-1:0];
    nib    = shown_value_i[{group, 2'b00} +: NibW];

    // digit = floor(v/w) - 10*floor(v/10w), both quotients by reciprocal multiply
    place     = PlaceW'(pos - FirstDec);
    prod_w    = ProdW'(shown_value_i) * ProdW'(RecipPlace[place]);
    prod_next = ProdW'(shown_value_i) * ProdW'(RecipNext[place]);
    quo_w     = (place == OnesPlace) ? shown_value_i : prod_w[ProdW-1 -: ValueW];
    quo_next  = prod_next[ProdW-1 -: ValueW];
    dec_diff  = quo_w - (quo_next << 3) - (quo_next << 1);
    dec_digit = dec_diff[NibW-1:0];

    point = (is_hex && pos == HexPointPos && entry_mode_i == ModeHex) ||
            (pos == LastPos && entry_mode_i == ModeDec);

    res_o.digit_index     = pos;
    res_o.segment_pattern = {point, SegFont[is_hex ? nib : dec_digit]};
    res_o.nibble_on       = is_hex;
    res_o.nibble_index    = is_hex ? group : '0;
    res_o.nibble_bits     = is_hex ? nib : '0;
  end

endmodule

`default_nettype wire
